// ===== src/dts_pkg.sv =====
// Package for the depth-first topological sort block.
// Holds shared constants, queue item type, result status codes and walker states.
// No dependencies.
package dts_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int VERTEX_W         = 6;
    localparam int COUNT_W          = 7;

    typedef enum logic [1:0] {
        ST_VERTEX = 2'd0,
        ST_CYCLE  = 2'd1,
        ST_DROP   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_EDGE,
        KIND_DROP,
        KIND_START
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [VERTEX_W-1:0]  from_v;
        logic [VERTEX_W-1:0]  to_v;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LINK,
        BK_SCAN,
        BK_LOAD,
        BK_EDGE,
        BK_EXPL,
        BK_POP,
        BK_SHOW,
        BK_FLAG
    } back_state_t;

endpackage

// ===== src/dfs_topological_sort.sv =====
// Depth-first topological sort with cycle detection. Add-edge items append to a
// per-vertex edge list, with an extra link step when the source list already holds
// edges. A start item walks the graph with a walker that reads one RAM word per step:
// it scans each vertex, reads then decides on each edge followed, loads the head of
// each new vertex that an edge leads to, and finishes each vertex; it then emits the
// vertices in reverse finish order, stalled by the result consumer. A start
// after dropped edges or a found cycle gives one flagged result. During a run the
// front queue takes up to two further items, then the input stalls until the run
// ends. The store is cleared as the last result of each run is issued.
module dfs_topological_sort #(
    parameter int MAX_VERTICES = dts_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dts_pkg::MAX_EDGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dts_pkg::COUNT_W-1:0]   cfg_data,       // vertex_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // from_vertex[5:0], to_vertex[11:6]
    input  logic [0:0]                    s_axis_tuser,   // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // vertex[5:0]
    output logic [1:0]                    m_axis_tuser,   // status
    output logic                          m_axis_tlast
);
    import dts_pkg::*;

    cmd_t               q_item;
    logic               q_valid, q_ready;
    logic [COUNT_W-1:0] n;

    dts_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready), .n(n)
    );

    dts_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready), .n(n),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

endmodule

// ===== src/dts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/dts_front.sv =====
// Front end: vertex count register, item classification and a two-entry queue.
// Depends on dts_pkg.
module dts_front #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dts_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,
    output dts_pkg::cmd_t                 q_item,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [dts_pkg::COUNT_W-1:0]   n
);
    import dts_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    logic [COUNT_W-1:0] vc_reg;
    cmd_t               q_reg [QDEPTH];
    logic [QPW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]       count_reg;
    logic [VERTEX_W-1:0] from_v, to_v;
    cmd_t               cls;
    logic               push, pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (vc_reg == '0)
            n = COUNT_W'(1);
        else if (vc_reg > COUNT_W'(MAX_VERTICES))
            n = COUNT_W'(MAX_VERTICES);
        else
            n = vc_reg;
    end

    assign from_v = s_axis_tdata[VERTEX_W-1:0];
    assign to_v   = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];

    always_comb
    begin
        cls.from_v = from_v;
        cls.to_v   = to_v;
        if (s_axis_tuser[0])
            cls.kind = KIND_START;
        else if ({1'b0, from_v} >= n || {1'b0, to_v} >= n)
            cls.kind = KIND_DROP;
        else
            cls.kind = KIND_EDGE;
    end

    assign s_axis_tready = (count_reg != (QPW+1)'(QDEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_item        = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg     <= COUNT_W'(1);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                vc_reg <= cfg_data;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== src/dts_back.sv =====
// Back end: edge store, depth-first walker with explicit stack, result output register.
// Depends on dts_pkg and dts_ram.
module dts_back #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dts_pkg::cmd_t                 q_item,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [dts_pkg::COUNT_W-1:0]   n,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import dts_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int ECW = EIW + 1;
    localparam int SW  = VW + ECW;
    localparam logic [ECW-1:0] LINK_NONE = ECW'(1) << EIW;

    back_state_t state_reg, state_next;
    logic [ECW-1:0]          edge_count_reg, edge_count_next;
    logic                    overflow_reg, overflow_next;
    logic [MAX_VERTICES-1:0] hv_reg, hv_next;
    logic [MAX_VERTICES-1:0] grey_reg, grey_next;
    logic [MAX_VERTICES-1:0] black_reg, black_next;
    logic [EIW-1:0]          link_edge_reg, link_edge_next;
    logic [VW:0]             s_reg, s_next;
    logic [VW:0]             sp_reg, sp_next;
    logic [VW:0]             pc_reg, pc_next;
    logic [VW-1:0]           idx_reg, idx_next;
    logic [VW-1:0]           top_v_reg, top_v_next;
    logic [ECW-1:0]          top_e_reg, top_e_next;
    logic                    hv_rd_reg, hv_rd_next;
    status_t                 flag_reg, flag_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [VERTEX_W-1:0]     out_vertex_reg, out_vertex_next;
    logic                    out_last_reg, out_last_next;

    logic                    head_we, head_re, tail_we, tail_re;
    logic [VW-1:0]           head_wa, head_ra, tail_wa, tail_ra;
    logic [EIW-1:0]          head_wd, tail_wd, head_rd, tail_rd;
    logic                    tgt_we, nxt_we, edge_re;
    logic [EIW-1:0]          tgt_wa, nxt_wa, edge_ra;
    logic [VERTEX_W-1:0]     tgt_wd, tgt_rd;
    logic [ECW-1:0]          nxt_wd, nxt_rd;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_wa, stk_ra;
    logic [SW-1:0]           stk_wd, stk_rd;
    logic                    post_we, post_re;
    logic [VW-1:0]           post_wa, post_ra;
    logic [VERTEX_W-1:0]     post_wd, post_rd;

    logic                    out_free;
    logic [VW-1:0]           s_idx, from_idx, t_idx;
    logic                    t_stale;
    logic [VW:0]             sp_m1, sp_m2, pc_m1;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_idx    = s_reg[VW-1:0];
    assign from_idx = q_item.from_v[VW-1:0];
    assign t_idx    = tgt_rd[VW-1:0];
    assign t_stale  = ({1'b0, tgt_rd} >= n);
    assign sp_m1    = sp_reg - (VW+1)'(1);
    assign sp_m2    = sp_reg - (VW+1)'(2);
    assign pc_m1    = pc_reg - (VW+1)'(1);
    assign q_ready  = (state_reg == BK_IDLE);

    dts_ram #(.WIDTH(EIW), .DEPTH(MAX_VERTICES)) u_head (
        .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
        .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd)
    );
    dts_ram #(.WIDTH(EIW), .DEPTH(MAX_VERTICES)) u_tail (
        .clk(clk), .wr_en(tail_we), .wr_addr(tail_wa), .wr_data(tail_wd),
        .rd_en(tail_re), .rd_addr(tail_ra), .rd_data(tail_rd)
    );
    dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_EDGES)) u_target (
        .clk(clk), .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
        .rd_en(edge_re), .rd_addr(edge_ra), .rd_data(tgt_rd)
    );
    dts_ram #(.WIDTH(ECW), .DEPTH(MAX_EDGES)) u_next (
        .clk(clk), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
        .rd_en(edge_re), .rd_addr(edge_ra), .rd_data(nxt_rd)
    );
    dts_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
        .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
    );
    dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_post (
        .clk(clk), .wr_en(post_we), .wr_addr(post_wa), .wr_data(post_wd),
        .rd_en(post_re), .rd_addr(post_ra), .rd_data(post_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        KIND_START:
                            state_next = overflow_reg ? BK_FLAG : BK_SCAN;
                        KIND_EDGE:
                            if (edge_count_reg != ECW'(MAX_EDGES) && hv_reg[from_idx])
                                state_next = BK_LINK;
                        default: ;
                    endcase
                end
            end
            BK_LINK: state_next = BK_IDLE;
            BK_SCAN:
            begin
                if (s_reg == n[VW:0])
                    state_next = BK_SHOW;
                else if (!grey_reg[s_idx] && !black_reg[s_idx])
                    state_next = BK_LOAD;
            end
            BK_LOAD: state_next = BK_EDGE;
            BK_EDGE:
            begin
                if (!top_e_reg[EIW])
                    state_next = BK_EXPL;
                else if (sp_reg == (VW+1)'(1))
                    state_next = BK_SCAN;
                else
                    state_next = BK_POP;
            end
            BK_POP: state_next = BK_EDGE;
            BK_EXPL:
            begin
                if (t_stale)
                    state_next = BK_EDGE;
                else if (grey_reg[t_idx])
                    state_next = BK_FLAG;
                else if (black_reg[t_idx])
                    state_next = BK_EDGE;
                else
                    state_next = BK_LOAD;
            end
            BK_SHOW:
                if (out_free && idx_reg == '0)
                    state_next = BK_IDLE;
            BK_FLAG:
                if (out_free)
                    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        edge_count_next = edge_count_reg;
        overflow_next   = overflow_reg;
        hv_next         = hv_reg;
        grey_next       = grey_reg;
        black_next      = black_reg;
        link_edge_next  = link_edge_reg;
        s_next          = s_reg;
        sp_next         = sp_reg;
        pc_next         = pc_reg;
        idx_next        = idx_reg;
        top_v_next      = top_v_reg;
        top_e_next      = top_e_reg;
        hv_rd_next      = hv_rd_reg;
        flag_next       = flag_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;

        head_we = 1'b0; head_wa = from_idx; head_wd = edge_count_reg[EIW-1:0];
        head_re = 1'b0; head_ra = s_idx;
        tail_we = 1'b0; tail_wa = from_idx; tail_wd = edge_count_reg[EIW-1:0];
        tail_re = 1'b0; tail_ra = from_idx;
        tgt_we  = 1'b0; tgt_wa  = edge_count_reg[EIW-1:0]; tgt_wd = q_item.to_v;
        nxt_we  = 1'b0; nxt_wa  = edge_count_reg[EIW-1:0]; nxt_wd = LINK_NONE;
        edge_re = 1'b0; edge_ra = top_e_reg[EIW-1:0];
        stk_we  = 1'b0; stk_wa  = sp_m1[VW-1:0]; stk_wd = {top_v_reg, nxt_rd};
        stk_re  = 1'b0; stk_ra  = sp_m2[VW-1:0];
        post_we = 1'b0; post_wa = pc_reg[VW-1:0]; post_wd = VERTEX_W'(top_v_reg);
        post_re = 1'b0; post_ra = pc_m1[VW-1:0];

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        KIND_START:
                        begin
                            flag_next  = ST_DROP;
                            grey_next  = '0;
                            black_next = '0;
                            s_next     = '0;
                            pc_next    = '0;
                        end
                        KIND_DROP:
                            overflow_next = 1'b1;
                        KIND_EDGE:
                        begin
                            if (edge_count_reg == ECW'(MAX_EDGES))
                                overflow_next = 1'b1;
                            else
                            begin
                                tgt_we  = 1'b1;
                                nxt_we  = 1'b1;
                                tail_we = 1'b1;
                                link_edge_next  = edge_count_reg[EIW-1:0];
                                edge_count_next = edge_count_reg + ECW'(1);
                                if (hv_reg[from_idx])
                                    tail_re = 1'b1;
                                else
                                begin
                                    head_we           = 1'b1;
                                    hv_next[from_idx] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_LINK:
            begin
                nxt_we = 1'b1;
                nxt_wa = tail_rd;
                nxt_wd = {1'b0, link_edge_reg};
            end
            BK_SCAN:
            begin
                if (s_reg == n[VW:0])
                begin
                    idx_next = pc_m1[VW-1:0];
                    post_re  = 1'b1;
                end
                else if (grey_reg[s_idx] || black_reg[s_idx])
                    s_next = s_reg + (VW+1)'(1);
                else
                begin
                    grey_next[s_idx] = 1'b1;
                    top_v_next       = s_idx;
                    sp_next          = (VW+1)'(1);
                    head_re          = 1'b1;
                    hv_rd_next       = hv_reg[s_idx];
                end
            end
            BK_LOAD:
                top_e_next = hv_rd_reg ? {1'b0, head_rd} : LINK_NONE;
            BK_EDGE:
            begin
                if (!top_e_reg[EIW])
                    edge_re = 1'b1;
                else
                begin
                    post_we               = 1'b1;
                    pc_next               = pc_reg + (VW+1)'(1);
                    grey_next[top_v_reg]  = 1'b0;
                    black_next[top_v_reg] = 1'b1;
                    sp_next               = sp_m1;
                    if (sp_reg != (VW+1)'(1))
                        stk_re = 1'b1;
                end
            end
            BK_POP:
            begin
                top_v_next = stk_rd[SW-1:ECW];
                top_e_next = stk_rd[ECW-1:0];
            end
            BK_EXPL:
            begin
                top_e_next = nxt_rd;
                if (t_stale)
                    ;
                else if (grey_reg[t_idx])
                    flag_next = ST_CYCLE;
                else if (!black_reg[t_idx])
                begin
                    stk_we           = 1'b1;
                    top_v_next       = t_idx;
                    grey_next[t_idx] = 1'b1;
                    sp_next          = sp_reg + (VW+1)'(1);
                    head_re          = 1'b1;
                    head_ra          = t_idx;
                    hv_rd_next       = hv_reg[t_idx];
                end
            end
            BK_SHOW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_VERTEX;
                    out_vertex_next = post_rd;
                    out_last_next   = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        hv_next         = '0;
                        edge_count_next = '0;
                        overflow_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - VW'(1);
                        post_re  = 1'b1;
                        post_ra  = idx_reg - VW'(1);
                    end
                end
            end
            BK_FLAG:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = flag_reg;
                    out_vertex_next = '0;
                    out_last_next   = 1'b1;
                    hv_next         = '0;
                    edge_count_next = '0;
                    overflow_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            hv_reg         <= '0;
            grey_reg       <= '0;
            black_reg      <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            overflow_reg   <= overflow_next;
            hv_reg         <= hv_next;
            grey_reg       <= grey_next;
            black_reg      <= black_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_edge_reg  <= link_edge_next;
        s_reg          <= s_next;
        pc_reg         <= pc_next;
        idx_reg        <= idx_next;
        top_v_reg      <= top_v_next;
        top_e_reg      <= top_e_next;
        hv_rd_reg      <= hv_rd_next;
        flag_reg       <= flag_next;
        out_status_reg <= out_status_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 8'(out_vertex_reg);
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_marks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (grey_reg & black_reg) == '0)
        else $error("vertex both grey and black");
    a_edge_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");
    a_stack_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EDGE || state_reg == BK_EXPL) |-> sp_reg != '0)
        else $error("walk step with empty stack");
    a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FLAG && out_free) |=> (edge_count_reg == '0 && !overflow_reg))
        else $error("store not cleared after flagged run");
`endif

endmodule
